[rtl/core/sptt_pkg.sv]
package sptt_pkg;

   // fixed field widths
   localparam int FUNC_W       = 2;
   localparam int COEF_W       = 32;
   localparam int EXP_PORT_W   = 16;
   localparam int TERM_INDEX_W = 6;
   localparam int COUNT_PORT_W = 6;
   localparam int STATUS_W     = 2;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_TERM = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

   localparam logic [COEF_W-1:0] COEF_MAX = 32'h7fff_ffff;
   localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic decide;
      logic shift;
      logic shrink;
      logic respond;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic table_empty;
      logic scan_last;
      logic remove;
      logic shift_more;
   } stat_type;

endpackage

[rtl/core/sparse_polynomial_term_table.sv]
// channel   | handshake       | payload
// ----------+-----------------+--------------------------------------------------
// request   | start, busy     | req_func, req_coef_in, req_exp_in, req_term_index
// response  | rsp_valid       | rsp_status, rsp_coef_out, rsp_exp_out,
//           |                 | rsp_term_count, rsp_degree, rsp_is_empty
//
// a request beat is taken on a rising edge with start high and busy low
// one request at a time: after accept the controller scans the term memory, decides and
// responds; a removal adds a shift-down of the terms above the hit and a shrink step
// rsp_valid is high for one cycle only and the payload holds until the next response; the receiver cannot stall it
// reset (synchronous, active high) empties the table and returns the controller to idle
module sparse_polynomial_term_table #(
   parameter int MAX_TERMS = 32,
   parameter int EXP_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic        [sptt_pkg::FUNC_W-1:0]       req_func,
   input  logic signed [sptt_pkg::COEF_W-1:0]       req_coef_in,
   input  logic        [sptt_pkg::EXP_PORT_W-1:0]   req_exp_in,
   input  logic        [sptt_pkg::TERM_INDEX_W-1:0] req_term_index,
   output logic                                   rsp_valid,
   output logic        [sptt_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [sptt_pkg::COEF_W-1:0]       rsp_coef_out,
   output logic        [sptt_pkg::EXP_PORT_W-1:0]   rsp_exp_out,
   output logic        [sptt_pkg::COUNT_PORT_W-1:0] rsp_term_count,
   output logic        [sptt_pkg::EXP_PORT_W-1:0]   rsp_degree,
   output logic                                   rsp_is_empty
);
   import sptt_pkg::*;

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: scan, decide, optional shift-down, respond
   sptt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // datapath: term memory, scan accumulators (match, degree), saturating add
   sptt_dpath #(
      .MAX_TERMS (MAX_TERMS),
      .EXP_BITS  (EXP_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_func),
      .req_coef_in    (req_coef_in),
      .req_exp_in     (req_exp_in),
      .req_term_index (req_term_index),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_coef_out   (rsp_coef_out),
      .rsp_exp_out    (rsp_exp_out),
      .rsp_term_count (rsp_term_count),
      .rsp_degree     (rsp_degree),
      .rsp_is_empty   (rsp_is_empty)
   );

endmodule

[rtl/core/sptt_ctrl.sv]
module sptt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  sptt_pkg::stat_type stat,
   output logic               busy,
   output sptt_pkg::cmd_type  cmd
);
   import sptt_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_DRAIN   = 3'd2;
   localparam logic [2:0] S_DECIDE  = 3'd3;
   localparam logic [2:0] S_SHIFT   = 3'd4;
   localparam logic [2:0] S_SHRINK  = 3'd5;
   localparam logic [2:0] S_RESPOND = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.table_empty) begin
               state_in = S_DECIDE;
            end else begin
               cmd.scan = 1'b1;
               if (stat.scan_last) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.remove ? S_SHIFT : S_RESPOND;
         end
         S_SHIFT: begin
            if (stat.shift_more) begin
               cmd.shift = 1'b1;
            end else begin
               state_in = S_SHRINK;
            end
         end
         S_SHRINK: begin
            cmd.shrink = 1'b1;
            state_in   = S_RESPOND;
         end
         S_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[rtl/core/sptt_dpath.sv]
module sptt_dpath #(
   parameter int MAX_TERMS = 32,
   parameter int EXP_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sptt_pkg::cmd_type                      cmd,
   output sptt_pkg::stat_type                     stat,
   input  logic        [sptt_pkg::FUNC_W-1:0]       req_func,
   input  logic signed [sptt_pkg::COEF_W-1:0]       req_coef_in,
   input  logic        [sptt_pkg::EXP_PORT_W-1:0]   req_exp_in,
   input  logic        [sptt_pkg::TERM_INDEX_W-1:0] req_term_index,
   output logic                                   rsp_valid,
   output logic        [sptt_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [sptt_pkg::COEF_W-1:0]       rsp_coef_out,
   output logic        [sptt_pkg::EXP_PORT_W-1:0]   rsp_exp_out,
   output logic        [sptt_pkg::COUNT_PORT_W-1:0] rsp_term_count,
   output logic        [sptt_pkg::EXP_PORT_W-1:0]   rsp_degree,
   output logic                                   rsp_is_empty
);
   import sptt_pkg::*;

   localparam int CNT_W  = $clog2(MAX_TERMS + 1);
   localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CMP_W  = ((CNT_W > TERM_INDEX_W) ? CNT_W : TERM_INDEX_W) + 1;

   // term storage
   logic [COEF_W-1:0]   coef_mem [MAX_TERMS];
   logic [EXP_BITS-1:0] exp_mem  [MAX_TERMS];
   logic [COEF_W-1:0]   rd_coef_ff;
   logic [EXP_BITS-1:0] rd_exp_ff;

   // captured request
   logic [FUNC_W-1:0]       func_ff;
   logic [COEF_W-1:0]       coef_ff;
   logic [EXP_BITS-1:0]     exp_ff;
   logic [TERM_INDEX_W-1:0] idx_ff;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] vld_addr_ff;
   logic [CNT_W-1:0] wr_ptr_ff;
   logic             scan_vld_ff;
   logic             shift_vld_ff;

   // scan results
   logic                found_ff;
   logic [CNT_W-1:0]    pos_ff;
   logic [COEF_W-1:0]   hit_coef_ff;
   logic [EXP_BITS-1:0] hit_exp_ff;
   logic [EXP_BITS-1:0] max_all_ff;
   logic [EXP_BITS-1:0] max_other_ff;

   // held result
   logic [STATUS_W-1:0] res_status_ff;
   logic [COEF_W-1:0]   res_coef_ff;
   logic [EXP_BITS-1:0] res_exp_ff;
   logic [EXP_BITS-1:0] res_degree_ff;

   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [COEF_W-1:0]       rsp_coef_ff;
   logic [EXP_PORT_W-1:0]   rsp_exp_ff;
   logic [COUNT_PORT_W-1:0] rsp_count_ff;
   logic [EXP_PORT_W-1:0]   rsp_degree_ff;
   logic                    rsp_empty_ff;

   // decision
   logic [COEF_W:0]     sum_wide;
   logic [COEF_W-1:0]   sum_sat;
   logic                table_full;
   logic                idx_in_range;
   logic                scan_match;
   logic [STATUS_W-1:0] dec_status;
   logic [COEF_W-1:0]   dec_coef;
   logic [EXP_BITS-1:0] dec_exp;
   logic [EXP_BITS-1:0] dec_degree;
   logic                dec_write;
   logic                dec_append;
   logic                dec_remove;

   // memory port
   logic                wr_en;
   logic [CNT_W-1:0]    wr_addr;
   logic [COEF_W-1:0]   wr_coef;
   logic [EXP_BITS-1:0] wr_exp;
   logic                rd_en;

   assign rd_en = cmd.scan | cmd.shift;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wr_ptr_ff;
      wr_coef = rd_coef_ff;
      wr_exp  = rd_exp_ff;
      if (shift_vld_ff) begin
         wr_en = 1'b1;
      end else if (cmd.decide && dec_write) begin
         wr_en   = 1'b1;
         wr_addr = dec_append ? count_ff : pos_ff;
         wr_coef = dec_coef;
         wr_exp  = exp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_mem[wr_addr[ADDR_W-1:0]] <= wr_coef;
         exp_mem[wr_addr[ADDR_W-1:0]]  <= wr_exp;
      end
      if (rd_en) begin
         rd_coef_ff <= coef_mem[rd_ptr_ff[ADDR_W-1:0]];
         rd_exp_ff  <= exp_mem[rd_ptr_ff[ADDR_W-1:0]];
      end
   end

   // entry matches the exponent, or sits at the requested position
   always_comb begin
      if (func_ff == FUNC_TERM) begin
         scan_match = (CMP_W'(idx_ff) == (CMP_W'(vld_addr_ff) + CMP_W'(1)));
      end else begin
         scan_match = (rd_exp_ff == exp_ff);
      end
   end

   always_comb begin
      sum_wide = {hit_coef_ff[COEF_W-1], hit_coef_ff} + {coef_ff[COEF_W-1], coef_ff};
      if (sum_wide[COEF_W] != sum_wide[COEF_W-1]) begin
         sum_sat = sum_wide[COEF_W] ? COEF_MIN : COEF_MAX;
      end else begin
         sum_sat = sum_wide[COEF_W-1:0];
      end
   end

   assign table_full   = (count_ff == CNT_W'(MAX_TERMS));
   assign idx_in_range = (idx_ff != '0) && (CMP_W'(idx_ff) <= CMP_W'(count_ff));

   always_comb begin
      dec_status = ST_OK;
      dec_coef   = '0;
      dec_exp    = exp_ff;
      dec_write  = 1'b0;
      dec_append = 1'b0;
      dec_remove = 1'b0;
      case (func_ff)
         FUNC_ADD: begin
            if (found_ff) begin
               dec_coef = sum_sat;
               if (sum_sat == '0) begin
                  dec_remove = 1'b1;
               end else begin
                  dec_write = 1'b1;
               end
            end else if (coef_ff == '0) begin
               dec_coef = '0;
            end else if (table_full) begin
               dec_status = ST_FULL;
            end else begin
               dec_coef   = coef_ff;
               dec_write  = 1'b1;
               dec_append = 1'b1;
            end
         end
         FUNC_SET: begin
            if (found_ff) begin
               dec_coef = coef_ff;
               if (coef_ff == '0) begin
                  dec_remove = 1'b1;
               end else begin
                  dec_write = 1'b1;
               end
            end else begin
               dec_status = ST_NOT_FOUND;
            end
         end
         FUNC_READ: begin
            if (found_ff) begin
               dec_coef = hit_coef_ff;
            end else begin
               dec_status = ST_NOT_FOUND;
            end
         end
         default: begin
            if (idx_in_range) begin
               dec_coef = hit_coef_ff;
               dec_exp  = hit_exp_ff;
            end else begin
               dec_status = ST_BAD_INDEX;
               dec_exp    = '0;
            end
         end
      endcase
      if (dec_remove) begin
         dec_degree = max_other_ff;
      end else if (dec_append && (exp_ff > max_all_ff)) begin
         dec_degree = exp_ff;
      end else begin
         dec_degree = max_all_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.decide && dec_append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.shrink) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_vld_ff  <= 1'b0;
         shift_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_vld_ff  <= cmd.scan;
         shift_vld_ff <= cmd.shift;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff      <= req_func;
         coef_ff      <= req_coef_in;
         exp_ff       <= EXP_BITS'(req_exp_in);
         idx_ff       <= req_term_index;
         rd_ptr_ff    <= '0;
         found_ff     <= 1'b0;
         max_all_ff   <= '0;
         max_other_ff <= '0;
      end
      if (cmd.scan || cmd.shift) begin
         rd_ptr_ff   <= rd_ptr_ff + CNT_W'(1);
         vld_addr_ff <= rd_ptr_ff;
      end
      if (scan_vld_ff) begin
         if (scan_match) begin
            found_ff    <= 1'b1;
            pos_ff      <= vld_addr_ff;
            hit_coef_ff <= rd_coef_ff;
            hit_exp_ff  <= rd_exp_ff;
         end
         if (rd_exp_ff > max_all_ff) begin
            max_all_ff <= rd_exp_ff;
         end
         if ((rd_exp_ff != exp_ff) && (rd_exp_ff > max_other_ff)) begin
            max_other_ff <= rd_exp_ff;
         end
      end
      if (cmd.decide) begin
         res_status_ff <= dec_status;
         res_coef_ff   <= dec_coef;
         res_exp_ff    <= dec_exp;
         res_degree_ff <= dec_degree;
         rd_ptr_ff     <= pos_ff + CNT_W'(1);
         wr_ptr_ff     <= pos_ff;
      end
      if (shift_vld_ff) begin
         wr_ptr_ff <= wr_ptr_ff + CNT_W'(1);
      end
      if (cmd.respond) begin
         rsp_status_ff <= res_status_ff;
         rsp_coef_ff   <= res_coef_ff;
         rsp_exp_ff    <= EXP_PORT_W'(res_exp_ff);
         rsp_count_ff  <= COUNT_PORT_W'(count_ff);
         rsp_degree_ff <= EXP_PORT_W'(res_degree_ff);
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   assign stat.table_empty = (count_ff == '0);
   assign stat.scan_last   = ((rd_ptr_ff + CNT_W'(1)) == count_ff);
   assign stat.remove      = dec_remove;
   assign stat.shift_more  = (rd_ptr_ff < count_ff);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_coef_out   = rsp_coef_ff;
   assign rsp_exp_out    = rsp_exp_ff;
   assign rsp_term_count = rsp_count_ff;
   assign rsp_degree     = rsp_degree_ff;
   assign rsp_is_empty   = rsp_empty_ff;

endmodule

[sim/term_table_checker.sv]
`timescale 1ns / 1ps

module term_table_checker #(
   parameter int MAX_TERMS = 32,
   parameter int EXP_BITS  = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic                                     busy,
   input  logic        [sptt_pkg::FUNC_W-1:0]       req_func,
   input  logic signed [sptt_pkg::COEF_W-1:0]       req_coef_in,
   input  logic        [sptt_pkg::EXP_PORT_W-1:0]   req_exp_in,
   input  logic        [sptt_pkg::TERM_INDEX_W-1:0] req_term_index,
   input  logic                                     rsp_valid,
   input  logic        [sptt_pkg::STATUS_W-1:0]     rsp_status,
   input  logic signed [sptt_pkg::COEF_W-1:0]       rsp_coef_out,
   input  logic        [sptt_pkg::EXP_PORT_W-1:0]   rsp_exp_out,
   input  logic        [sptt_pkg::COUNT_PORT_W-1:0] rsp_term_count,
   input  logic        [sptt_pkg::EXP_PORT_W-1:0]   rsp_degree,
   input  logic                                     rsp_is_empty,
   output int                                       fail_count,
   output int                                       pending,
   output int                                       checked,
   output int                                       full_drops
);
   import sptt_pkg::*;

   localparam int MAX_REPORTS = 10;
   localparam logic [EXP_PORT_W-1:0] EXP_MASK = (EXP_BITS >= EXP_PORT_W) ?
      {EXP_PORT_W{1'b1}} : EXP_PORT_W'((64'd1 << EXP_BITS) - 64'd1);

   typedef struct {
      logic        [STATUS_W-1:0]     status;
      logic signed [COEF_W-1:0]       coef;
      logic        [EXP_PORT_W-1:0]   exp_val;
      logic        [COUNT_PORT_W-1:0] term_count;
      logic        [EXP_PORT_W-1:0]   degree;
      logic                           is_empty;
   } term_reply_type;

   // shadow copy of the term list
   logic signed [COEF_W-1:0]     held_coefs [MAX_TERMS];
   logic        [EXP_PORT_W-1:0] held_exps  [MAX_TERMS];
   int                           held_count = 0;

   term_reply_type awaited_replies [$];
   int             n_fail    = 0;
   int             n_checked = 0;
   int             n_full    = 0;

   // remove one term and close the gap above it
   function automatic void drop_term(int pos);
      for (int i = pos; i + 1 < held_count; i++) begin
         held_coefs[i] = held_coefs[i + 1];
         held_exps[i]  = held_exps[i + 1];
      end
      held_count--;
   endfunction

   function automatic term_reply_type apply_term_op(logic [FUNC_W-1:0] op,
                                                    logic signed [COEF_W-1:0] c,
                                                    logic [EXP_PORT_W-1:0] e_in,
                                                    logic [TERM_INDEX_W-1:0] idx);
      term_reply_type          r;
      logic [EXP_PORT_W-1:0]   e;
      logic [EXP_PORT_W-1:0]   top_exp;
      int                      pos;
      longint                  total;
      e = e_in & EXP_MASK;
      r.status  = ST_OK;
      r.coef    = '0;
      r.exp_val = e;
      pos = -1;
      for (int i = 0; i < held_count; i++) begin
         if (pos < 0 && held_exps[i] == e) pos = i;
      end
      case (op)
         FUNC_ADD: begin
            if (pos < 0) begin
               if (c == 0) begin
                  r.coef = '0;
               end else if (held_count >= MAX_TERMS) begin
                  r.status = ST_FULL;
               end else begin
                  held_coefs[held_count] = c;
                  held_exps[held_count]  = e;
                  held_count++;
                  r.coef = c;
               end
            end else begin
               total = longint'(held_coefs[pos]) + longint'(c);
               if (total > $signed(COEF_MAX)) total = $signed(COEF_MAX);
               if (total < $signed(COEF_MIN)) total = $signed(COEF_MIN);
               r.coef = COEF_W'(total);
               held_coefs[pos] = r.coef;
               if (r.coef == 0) drop_term(pos);
            end
         end
         FUNC_SET: begin
            if (pos < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               held_coefs[pos] = c;
               r.coef = c;
               if (c == 0) drop_term(pos);
            end
         end
         FUNC_READ: begin
            if (pos < 0) r.status = ST_NOT_FOUND;
            else r.coef = held_coefs[pos];
         end
         default: begin
            if (idx >= 1 && idx <= held_count && idx <= MAX_TERMS) begin
               r.coef    = held_coefs[idx - 1];
               r.exp_val = held_exps[idx - 1];
            end else begin
               r.status  = ST_BAD_INDEX;
               r.exp_val = '0;
            end
         end
      endcase
      top_exp = '0;
      for (int i = 0; i < held_count; i++) begin
         if (held_exps[i] > top_exp) top_exp = held_exps[i];
      end
      r.term_count = COUNT_PORT_W'(held_count);
      r.degree     = top_exp;
      r.is_empty   = (held_count == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      term_reply_type seen;
      term_reply_type want;
      if (reset) begin
         held_count = 0;
         awaited_replies.delete();
      end else begin
         if (start && !busy)
            awaited_replies.push_back(apply_term_op(req_func, req_coef_in, req_exp_in,
                                                    req_term_index));
         if (rsp_valid) begin
            seen = '{status: rsp_status, coef: rsp_coef_out, exp_val: rsp_exp_out,
                     term_count: rsp_term_count, degree: rsp_degree,
                     is_empty: rsp_is_empty};
            n_checked++;
            if (awaited_replies.size() == 0) begin
               n_fail++;
               if (n_fail <= MAX_REPORTS)
                  $display("%0t: response beat with nothing outstanding", $time);
            end else begin
               want = awaited_replies.pop_front();
               if (seen.status !== want.status || seen.coef !== want.coef ||
                   seen.exp_val !== want.exp_val || seen.term_count !== want.term_count ||
                   seen.degree !== want.degree || seen.is_empty !== want.is_empty) begin
                  n_fail++;
                  if (n_fail <= MAX_REPORTS) begin
                     $display("%0t: expected st %0d coef %0d exp %0h cnt %0d deg %0h empty %0b",
                              $time, want.status, want.coef, want.exp_val, want.term_count,
                              want.degree, want.is_empty);
                     $display("%0t: actual   st %0d coef %0d exp %0h cnt %0d deg %0h empty %0b",
                              $time, seen.status, seen.coef, seen.exp_val, seen.term_count,
                              seen.degree, seen.is_empty);
                  end
               end else if (want.status == ST_FULL) begin
                  n_full++;
               end
            end
         end
      end
      fail_count <= n_fail;
      pending    <= awaited_replies.size();
      checked    <= n_checked;
      full_drops <= n_full;
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
   import sptt_pkg::*;

   localparam int TERM_SLOTS  = 32;
   localparam int EXP_WIDTH   = 16;
   localparam int ITEM_GOAL   = 1650;
   localparam int CYCLE_LIMIT = 1_000_000;
   // worst case is a scan plus a full compaction shift
   localparam int SETTLE_CYCLES = 2 * TERM_SLOTS + 8;
   localparam int POOL_DEPTH    = 48;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic        [FUNC_W-1:0]       req_func;
   logic signed [COEF_W-1:0]       req_coef_in;
   logic        [EXP_PORT_W-1:0]   req_exp_in;
   logic        [TERM_INDEX_W-1:0] req_term_index;
   logic                           rsp_valid;
   logic        [STATUS_W-1:0]     rsp_status;
   logic signed [COEF_W-1:0]       rsp_coef_out;
   logic        [EXP_PORT_W-1:0]   rsp_exp_out;
   logic        [COUNT_PORT_W-1:0] rsp_term_count;
   logic        [EXP_PORT_W-1:0]   rsp_degree;
   logic                           rsp_is_empty;

   // figures handed back by the checker
   int fail_count;
   int pending;
   int checked;
   int full_drops;

   // stimulus bookkeeping
   int                    op_tally [4];
   int                    issued;
   int                    cycle_count;
   int                    pool_size;
   bit                    no_idle;
   logic [EXP_PORT_W-1:0] exp_pool [POOL_DEPTH];

   sparse_polynomial_term_table #(
      .MAX_TERMS (TERM_SLOTS),
      .EXP_BITS  (EXP_WIDTH)
   ) DUT (.*);

   // watches both channels, predicts every response and compares
   term_table_checker #(
      .MAX_TERMS (TERM_SLOTS),
      .EXP_BITS  (EXP_WIDTH)
   ) reply_check (
      .*,
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .full_drops (full_drops)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // coefficient mix: small values so sums hit zero, extremes for saturation,
   // and plain random words so every bit toggles
   function automatic logic signed [COEF_W-1:0] draw_coef();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return int'($urandom_range(0, 8)) - 4;
         4, 5:       return $urandom();
         6:          return COEF_MAX - $urandom_range(0, 3);
         7:          return COEF_MIN + $urandom_range(0, 3);
         default:    return int'($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   // mostly exponents from the current pool so terms get hit again,
   // now and then a stray one over the full port width
   function automatic logic [EXP_PORT_W-1:0] draw_exp();
      if ($urandom_range(0, 9) == 0) return EXP_PORT_W'($urandom());
      return exp_pool[$urandom_range(0, pool_size - 1)];
   endfunction

   // indexes mostly around the live range, sometimes across all six bits
   function automatic logic [TERM_INDEX_W-1:0] draw_index();
      if ($urandom_range(0, 6) == 0) return TERM_INDEX_W'($urandom_range(0, 63));
      return TERM_INDEX_W'($urandom_range(0, TERM_SLOTS + 1));
   endfunction

   // one request beat: optional idle gap, then hold start until taken
   task automatic issue_term_op(input logic [FUNC_W-1:0]       op,
                                input logic signed [COEF_W-1:0] coef,
                                input logic [EXP_PORT_W-1:0]   exp_val,
                                input logic [TERM_INDEX_W-1:0] idx);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_func       <= op;
      req_coef_in    <= coef;
      req_exp_in     <= exp_val;
      req_term_index <= idx;
      // busy read here is the value before this edge
      do @(posedge clock); while (busy);
      op_tally[op]++;
      issued++;
   endtask

   // hold off until every outstanding response has come back
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      logic [FUNC_W-1:0]       op;
      logic signed [COEF_W-1:0] coef;
      int                      phase_len;
      int                      phase_no;
      bit                      fill_phase;

      start          <= 1'b0;
      req_func       <= FUNC_ADD;
      req_coef_in    <= '0;
      req_exp_in     <= '0;
      req_term_index <= '0;
      reset          <= 1'b1;
      issued    = 0;
      no_idle   = 1'b0;
      pool_size = 1;
      phase_no  = 0;
      foreach (op_tally[i]) op_tally[i] = 0;
      foreach (exp_pool[i]) exp_pool[i] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // queries against an empty table
      issue_term_op(FUNC_TERM, '0, '0, 6'd1);
      issue_term_op(FUNC_READ, '0, 16'h0000, '0);
      issue_term_op(FUNC_SET, 32'sd5, 16'h0005, '0);
      // zero added to an absent exponent stores nothing
      issue_term_op(FUNC_ADD, '0, 16'h0007, '0);
      // saturation at both ends of the coefficient range
      issue_term_op(FUNC_ADD, COEF_MAX, 16'hffff, '0);
      issue_term_op(FUNC_ADD, 32'sd1, 16'hffff, '0);
      issue_term_op(FUNC_ADD, COEF_MIN, 16'h0000, '0);
      issue_term_op(FUNC_ADD, -32'sd1, 16'h0000, '0);
      issue_term_op(FUNC_ADD, 32'sd9, 16'h0003, '0);
      // term reads: index zero, last held, one past the end, all ones
      issue_term_op(FUNC_TERM, '0, '0, 6'd0);
      issue_term_op(FUNC_TERM, '0, '0, 6'd3);
      issue_term_op(FUNC_TERM, '0, '0, 6'd4);
      issue_term_op(FUNC_TERM, '0, '0, 6'd63);
      issue_term_op(FUNC_READ, '0, 16'hffff, '0);
      // replace, then cancel to zero so the middle term goes and the top shifts down
      issue_term_op(FUNC_SET, 32'sd12345, 16'h0000, '0);
      issue_term_op(FUNC_ADD, -32'sd12345, 16'h0000, '0);
      // set to zero removes the first term
      issue_term_op(FUNC_SET, '0, 16'hffff, '0);
      issue_term_op(FUNC_TERM, '0, '0, 6'd1);
      // last term cancelled, table empty again
      issue_term_op(FUNC_ADD, -32'sd9, 16'h0003, '0);
      issue_term_op(FUNC_READ, '0, 16'h0003, '0);
      issue_term_op(FUNC_ADD, $urandom() | 32'd1, EXP_PORT_W'($urandom()), '0);
      issue_term_op(FUNC_TERM, '0, '0, 6'd1);
      wait_for_drain();

      // ---- random part, in phases ----
      // a fill phase uses a wide pool with nonzero adds so the table runs full;
      // small pools keep hitting the same terms so removals and shifts are frequent
      while (issued < ITEM_GOAL) begin
         fill_phase = (phase_no == 0) || ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 3))
            0:       pool_size = 3;
            1:       pool_size = 8;
            2:       pool_size = 20;
            default: pool_size = 40;
         endcase
         if (fill_phase) pool_size = POOL_DEPTH;
         // low bits carry the slot number so pool entries never collide
         foreach (exp_pool[k]) exp_pool[k] = {10'($urandom()), 6'(k)};
         if ($urandom_range(0, 1) == 1) begin
            exp_pool[0] = 16'hffff;
            exp_pool[1] = 16'h0000;
         end
         no_idle   = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(30, 120);
         for (int n = 0; n < phase_len && issued < ITEM_GOAL; n++) begin
            if (fill_phase) begin
               op = ($urandom_range(0, 4) == 0) ? FUNC_TERM : FUNC_ADD;
            end else begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: op = FUNC_ADD;
                  4, 5:       op = FUNC_SET;
                  6, 7:       op = FUNC_READ;
                  default:    op = FUNC_TERM;
               endcase
            end
            coef = draw_coef();
            if (fill_phase) begin
               while (coef == 0) coef = draw_coef();
            end else if (op == FUNC_SET && $urandom_range(0, 3) == 0) begin
               coef = '0;
            end
            issue_term_op(op, coef, draw_exp(), draw_index());
         end
         // pause the sender until the block has answered everything
         wait_for_drain();
         phase_no++;
      end

      // let any stray response show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests, %0d phases: %0d add %0d set %0d read %0d term",
               issued, phase_no, op_tally[FUNC_ADD], op_tally[FUNC_SET], op_tally[FUNC_READ],
               op_tally[FUNC_TERM]);
      $display("%0d responses compared, %0d dropped on a full table, %0d mismatches",
               checked, full_drops, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
